### hw/rtl/bdll_pkg.sv
`default_nettype none

package bdll_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_REM_POS   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic                load;
        logic                decide;
        logic                ins_alloc;
        logic                ins_link;
        logic                walk;
        logic                unl_link;
        logic                unl_free;
        logic                result;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic is_ins;
        logic full;
        logic empty;
        logic range_err;
        logic at_target;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

### hw/rtl/bdll_in_if.sv
`default_nettype none

interface bdll_in_if import bdll_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink (input valid, input action, input value, input position, output ready);
endinterface

`default_nettype wire

### hw/rtl/bdll_out_if.sv
`default_nettype none

interface bdll_out_if import bdll_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [LEN_W-1:0]           length;
    logic signed [VALUE_W-1:0]  front_value;

    modport source (output valid, output status, output removed_value, output length,
                    output front_value, input ready);
    modport sink (input valid, input status, input removed_value, input length,
                  input front_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/bounded_doubly_linked_list_unit.sv
`default_nettype none

// Bounded doubly linked list of signed values in a node memory of CAPACITY entries, with a
// free list. Each input transfer inserts at the front or back, removes the front, or removes
// the element at a position counted from the front; each produces one output transfer with
// status, removed value, new length and front value. A removal walks the next links through
// the node memory one hop per cycle, the front counting as position zero. The next input
// transfer can be taken in the cycle that output valid rises. One item is in work at a time;
// the output register lets the next item be taken while a result waits. No clearing pass
// after reset: the free list is grown from a high-water mark.
module bounded_doubly_linked_list_unit import bdll_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdll_in_if.sink    in_ch,
    bdll_out_if.source out_ch
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign in_ch.ready = in_ready;

    bdll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdll_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_action   (in_ch.action),
        .in_value    (in_ch.value),
        .in_position (in_ch.position),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

### hw/rtl/bdll_ctrl.sv
`default_nettype none

module bdll_ctrl import bdll_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECIDE    = 3'd1;
    localparam logic [2:0] S_INS_ALLOC = 3'd2;
    localparam logic [2:0] S_INS_LINK  = 3'd3;
    localparam logic [2:0] S_WALK      = 3'd4;
    localparam logic [2:0] S_UNL_LINK  = 3'd5;
    localparam logic [2:0] S_UNL_FREE  = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [STATUS_W-1:0] code_reg;
    logic [STATUS_W-1:0] code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                code_next  = ST_OK;
                if (stat.is_ins)
                begin
                    if (stat.full)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_INS_ALLOC;
                    end
                end
                else if (stat.empty)
                begin
                    code_next  = ST_EMPTY;
                    state_next = S_RESP;
                end
                else if (stat.range_err)
                begin
                    code_next  = ST_RANGE;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_INS_ALLOC:
            begin
                cmd.ins_alloc = 1'b1;
                state_next    = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                state_next   = S_RESP;
            end
            S_WALK:
            begin
                if (stat.at_target)
                begin
                    state_next = S_UNL_LINK;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_UNL_LINK:
            begin
                cmd.unl_link = 1'b1;
                state_next   = S_UNL_FREE;
            end
            S_UNL_FREE:
            begin
                cmd.unl_free = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the walk only starts on a position that lies inside the list
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && state_next == S_WALK) |-> (!stat.empty && !stat.range_err))
        else $error("walk started on an empty list or a bad position");

    a_accept_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("transfer taken outside idle");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && code_next == ST_FULL) |-> stat.is_ins)
        else $error("full status on a removal");

endmodule

`default_nettype wire

### hw/rtl/bdll_dpath.sv
`default_nettype none

module bdll_dpath import bdll_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output stat_t                          stat,
    input  wire logic [ACTION_W-1:0]       in_action,
    input  wire logic signed [VALUE_W-1:0] in_value,
    input  wire logic [POS_W-1:0]          in_position,
    bdll_out_if.source                     out_ch
);

    localparam int PW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    logic [PW-1:0]         next_mem [CAPACITY];
    logic [PW-1:0]         prev_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];

    logic [ACTION_W-1:0]   act_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [POS_W-1:0]      target_reg;
    logic [PW-1:0]         head_reg;
    logic [PW-1:0]         tail_reg;
    logic [PW-1:0]         free_reg;
    logic [PW-1:0]         fresh_reg;
    logic [PW-1:0]         count_reg;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [PW-1:0]         cur_reg;
    logic [POS_W-1:0]      k_reg;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic [PW-1:0]         rd_next_reg;
    logic [PW-1:0]         rd_prev_reg;
    logic [DATA_WIDTH-1:0] rd_val_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [VALUE_W-1:0]    out_removed_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic [VALUE_W-1:0]    out_front_reg;

    logic                  is_ins;
    logic                  is_front;
    logic [PW-1:0]         start_node;
    logic [PW-1:0]         rd_addr;
    logic                  link_rd_en;
    logic                  val_rd_en;
    logic                  next_we;
    logic [PW-1:0]         next_wa;
    logic [PW-1:0]         next_wd;
    logic                  prev_we;
    logic [PW-1:0]         prev_wa;
    logic [PW-1:0]         prev_wd;
    logic [63:0]           in_wide;
    logic [63:0]           removed_ext;
    logic [63:0]           front_ext;

    assign is_ins     = (act_reg == ACT_INS_FRONT) || (act_reg == ACT_INS_BACK);
    assign is_front   = (act_reg == ACT_INS_FRONT);
    assign start_node = is_ins ? free_reg : head_reg;
    assign rd_addr    = cmd.decide ? start_node : rd_next_reg;
    assign link_rd_en = cmd.decide | cmd.walk;
    assign val_rd_en  = link_rd_en | cmd.unl_link;

    assign in_wide     = 64'(in_value);
    assign removed_ext = 64'(signed'(removed_reg));
    assign front_ext   = 64'(signed'(front_reg));

    assign stat.is_ins    = is_ins;
    assign stat.full      = (count_reg == NIL);
    assign stat.empty     = (count_reg == '0) || (head_reg == NIL);
    assign stat.range_err = CMPW'(target_reg) >= CMPW'(count_reg);
    assign stat.at_target = (k_reg == target_reg);
    assign stat.out_busy  = out_valid_reg && !out_ch.ready;

    always_comb
    begin
        next_we = 1'b0;
        next_wa = cur_reg;
        next_wd = NIL;
        if (cmd.ins_alloc)
        begin
            next_we = 1'b1;
            next_wd = is_front ? head_reg : NIL;
        end
        else if (cmd.ins_link && !is_front && tail_reg != NIL)
        begin
            next_we = 1'b1;
            next_wa = tail_reg;
            next_wd = cur_reg;
        end
        else if (cmd.unl_link && rd_prev_reg != NIL)
        begin
            next_we = 1'b1;
            next_wa = rd_prev_reg;
            next_wd = rd_next_reg;
        end
        else if (cmd.unl_free)
        begin
            next_we = 1'b1;
            next_wd = free_reg;
        end
    end

    always_comb
    begin
        prev_we = 1'b0;
        prev_wa = cur_reg;
        prev_wd = NIL;
        if (cmd.ins_alloc)
        begin
            prev_we = 1'b1;
            prev_wd = is_front ? NIL : tail_reg;
        end
        else if (cmd.ins_link && is_front && head_reg != NIL)
        begin
            prev_we = 1'b1;
            prev_wa = head_reg;
            prev_wd = cur_reg;
        end
        else if (cmd.unl_link && rd_next_reg != NIL)
        begin
            prev_we = 1'b1;
            prev_wa = rd_next_reg;
            prev_wd = rd_prev_reg;
        end
    end

    // node memories, read-first
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa[AW-1:0]] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa[AW-1:0]] <= prev_wd;
        end
        if (cmd.ins_alloc)
        begin
            val_mem[cur_reg[AW-1:0]] <= val_reg;
        end
        if (link_rd_en)
        begin
            rd_next_reg <= next_mem[rd_addr[AW-1:0]];
            rd_prev_reg <= prev_mem[rd_addr[AW-1:0]];
        end
        if (val_rd_en)
        begin
            rd_val_reg <= val_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= in_action;
            val_reg    <= in_wide[DATA_WIDTH-1:0];
            target_reg <= (in_action == ACT_REM_POS) ? in_position : '0;
        end
        if (cmd.decide)
        begin
            cur_reg <= start_node;
            k_reg   <= '0;
        end
        else if (cmd.walk)
        begin
            cur_reg <= rd_next_reg;
            k_reg   <= k_reg + 1'b1;
        end
        if (cmd.unl_link)
        begin
            removed_reg <= rd_val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= '0;
            fresh_reg <= '0;
            count_reg <= '0;
            front_reg <= '0;
        end
        else
        begin
            if (cmd.ins_alloc)
            begin
                // nodes at or above fresh_reg have never been linked
                if (cur_reg == fresh_reg)
                begin
                    free_reg  <= cur_reg + 1'b1;
                    fresh_reg <= fresh_reg + 1'b1;
                end
                else
                begin
                    free_reg <= rd_next_reg;
                end
            end
            if (cmd.ins_link)
            begin
                count_reg <= count_reg + 1'b1;
                if (is_front)
                begin
                    if (head_reg == NIL)
                    begin
                        tail_reg <= cur_reg;
                    end
                    head_reg  <= cur_reg;
                    front_reg <= val_reg;
                end
                else
                begin
                    if (tail_reg == NIL)
                    begin
                        head_reg  <= cur_reg;
                        front_reg <= val_reg;
                    end
                    tail_reg <= cur_reg;
                end
            end
            if (cmd.unl_link)
            begin
                count_reg <= count_reg - 1'b1;
                if (rd_prev_reg == NIL)
                begin
                    head_reg <= rd_next_reg;
                end
                if (rd_next_reg == NIL)
                begin
                    tail_reg <= rd_prev_reg;
                end
            end
            if (cmd.unl_free)
            begin
                free_reg <= cur_reg;
                // rd_val_reg holds the successor's value here
                if (rd_prev_reg == NIL)
                begin
                    front_reg <= (rd_next_reg == NIL) ? '0 : rd_val_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            out_status_reg  <= cmd.code;
            out_removed_reg <= (cmd.code == ST_OK && !is_ins) ? removed_ext[VALUE_W-1:0] : '0;
            out_length_reg  <= LEN_W'(count_reg);
            out_front_reg   <= front_ext[VALUE_W-1:0];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.removed_value = out_removed_reg;
    assign out_ch.length        = out_length_reg;
    assign out_ch.front_value   = out_front_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("element count above capacity");

    a_head_tail_null: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (tail_reg == NIL))
        else $error("head and tail disagree on empty");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == NIL))
        else $error("count and head disagree on empty");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_link |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not bump the count");

endmodule

`default_nettype wire

### sim/bounded_doubly_linked_list_unit_tb.sv
`default_nettype none

module bounded_doubly_linked_list_unit_tb;
    import bdll_pkg::*;

    localparam int LIST_CAPACITY = 64;
    localparam int ITEM_TOTAL    = 1800;
    localparam int DRAIN_CYCLES  = 80;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [LEN_W-1:0]          length;
        logic signed [VALUE_W-1:0] front_value;
    } reply_t;

    typedef enum {GROW, SHRINK, CHURN} phase_t;

    logic clk = 1'b0;
    logic rst_n;

    bdll_in_if  in_ch ();
    bdll_out_if out_ch ();

    bounded_doubly_linked_list_unit #(
        .CAPACITY   (LIST_CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    logic signed [VALUE_W-1:0] list_contents[$];
    request_t                  pending_requests[$];
    reply_t                    awaited_replies[$];

    int planned_length = 0;
    int total_items    = 0;
    int accepted_items = 0;
    int delivered      = 0;
    int failures       = 0;
    int idle_cycles    = 0;

    int send_gap    = 0;
    int recv_gap    = 0;
    int hold_left   = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    request_t drive_req;
    request_t taken_req;
    reply_t   want;
    bit       offering;

    // Golden list kept as a queue, front at index zero
    function automatic reply_t apply_to_list(input request_t req);
        reply_t      rep;
        int unsigned target;
        rep.status        = ST_OK;
        rep.removed_value = '0;
        if (req.action == ACT_INS_FRONT || req.action == ACT_INS_BACK)
        begin
            if (list_contents.size() >= LIST_CAPACITY)
                rep.status = ST_FULL;
            else if (req.action == ACT_INS_FRONT)
                list_contents.push_front(req.value);
            else
                list_contents.push_back(req.value);
        end
        else
        begin
            target = (req.action == ACT_REM_FRONT) ? 0 : req.position;
            if (list_contents.size() == 0)
                rep.status = ST_EMPTY;
            else if (target >= list_contents.size())
                rep.status = ST_RANGE;
            else
            begin
                rep.removed_value = list_contents[target];
                list_contents.delete(target);
            end
        end
        rep.length      = LEN_W'(list_contents.size());
        rep.front_value = (list_contents.size() != 0) ? list_contents[0] : '0;
        return rep;
    endfunction

    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        return POS_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (planned_length > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, planned_length - 1));
        else
            return random_position();
    endfunction

    task automatic add_request(input logic [ACTION_W-1:0] action,
                               input logic signed [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] position);
        request_t req;
        int       target;
        req.action   = action;
        req.value    = value;
        req.position = position;
        pending_requests.push_back(req);
        if (action == ACT_INS_FRONT || action == ACT_INS_BACK)
        begin
            if (planned_length < LIST_CAPACITY)
                planned_length++;
        end
        else
        begin
            target = (action == ACT_REM_FRONT) ? 0 : position;
            if (planned_length > target)
                planned_length--;
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expected,
                               input logic signed [31:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
            failures++;
        end
    endtask

    task automatic build_stimulus();
        phase_t mode;
        int     phase_len;
        int     ins_share;
        // empty list, single element, range errors, head/tail/middle removal
        add_request(ACT_REM_FRONT, 32'sh1234_5678, 6'd0);
        add_request(ACT_REM_POS, '0, 6'd0);
        add_request(ACT_INS_FRONT, 32'sh7FFF_FFFF, 6'd63);
        add_request(ACT_REM_POS, '0, 6'd1);
        add_request(ACT_REM_POS, '0, 6'd0);
        add_request(ACT_INS_BACK, 32'sh8000_0000, 6'd0);
        add_request(ACT_INS_FRONT, -1, 6'd0);
        add_request(ACT_INS_BACK, '0, 6'd0);
        add_request(ACT_INS_FRONT, 32'sd1, 6'd0);
        add_request(ACT_REM_POS, '0, 6'd63);
        add_request(ACT_REM_POS, -1, 6'd3);
        add_request(ACT_REM_POS, '0, 6'd1);
        add_request(ACT_REM_FRONT, '0, 6'd0);
        add_request(ACT_INS_BACK, 32'sh5555_5555, 6'd21);
        add_request(ACT_INS_BACK, 32'shAAAA_AAAA, 6'd42);
        add_request(ACT_REM_POS, '0, 6'd4);
        add_request(ACT_REM_POS, '0, 6'd0);
        add_request(ACT_REM_FRONT, '0, 6'd0);
        add_request(ACT_REM_FRONT, '0, 6'd0);
        add_request(ACT_REM_FRONT, '0, 6'd0);
        add_request(ACT_REM_POS, '0, 6'd63);

        // fill to capacity, push past it, then remove the last element
        while (planned_length < LIST_CAPACITY)
            add_request($urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT,
                        random_value(), random_position());
        add_request(ACT_INS_FRONT, random_value(), 6'd0);
        add_request(ACT_INS_BACK, random_value(), 6'd0);
        add_request(ACT_REM_POS, random_value(), 6'd63);

        while (pending_requests.size() < ITEM_TOTAL)
        begin
            mode      = phase_t'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 120);
            case (mode)
                GROW:    ins_share = 80;
                SHRINK:  ins_share = 20;
                default: ins_share = 50;
            endcase
            repeat (phase_len)
            begin
                if ($urandom_range(0, 99) < ins_share)
                    add_request($urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT,
                                random_value(), random_position());
                else if ($urandom_range(0, 3) == 0)
                    add_request(ACT_REM_FRONT, random_value(), random_position());
                else
                    add_request(ACT_REM_POS, random_value(), pick_position());
            end
        end
        total_items = pending_requests.size();
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.action   <= ACT_INS_FRONT;
            in_ch.value    <= '0;
            in_ch.position <= '0;
        end
        else
        begin
            offering = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                taken_req.action   = in_ch.action;
                taken_req.value    = in_ch.value;
                taken_req.position = in_ch.position;
                awaited_replies.push_back(apply_to_list(taken_req));
                accepted_items++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    drive_req       = pending_requests.pop_front();
                    in_ch.action   <= drive_req.action;
                    in_ch.value    <= drive_req.value;
                    in_ch.position <= drive_req.position;
                    in_ch.valid    <= 1'b1;
                    send_gap        = pick_gap(send_steady);
                    if ($urandom_range(0, 39) == 0)
                        send_steady = !send_steady;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d len %0d",
                             $time, out_ch.status, out_ch.length);
                    failures++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("removed_value", want.removed_value, out_ch.removed_value);
                    check_field("length", want.length, out_ch.length);
                    check_field("front_value", want.front_value, out_ch.front_value);
                end
                delivered++;
                // long back-pressure so the input side fills and stalls
                if (delivered == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                recv_gap      = pick_gap(recv_steady);
                if ($urandom_range(0, 39) == 0)
                    recv_steady = !recv_steady;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_items < total_items || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && awaited_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### bounded_doubly_linked_list_unit.f
hw/rtl/bdll_pkg.sv
hw/rtl/bdll_in_if.sv
hw/rtl/bdll_out_if.sv
hw/rtl/bdll_ctrl.sv
hw/rtl/bdll_dpath.sv
hw/rtl/bounded_doubly_linked_list_unit.sv
sim/bounded_doubly_linked_list_unit_tb.sv
